FILE: rtl/dmdf_pkg.sv
// Shared types and constants of the direct-mapped duplicate filter.
package dmdf_pkg;

    localparam int unsigned REQ_DEPTH_LOG2 = 2;
    localparam int unsigned RES_DEPTH_LOG2 = 2;
    localparam int unsigned RES_DEPTH      = 1 << RES_DEPTH_LOG2;
    localparam int unsigned ADDR_W         = 64;
    localparam int unsigned COUNT_W        = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic MODE_CHECK = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] target_address;
    } dmdf_req_t;

    typedef struct packed {
        logic               is_new;
        logic [COUNT_W-1:0] total_checks;
        logic [COUNT_W-1:0] shorted_checks;
    } dmdf_res_t;

    typedef struct packed {
        logic take;
        logic sweeping;
        logic push;
    } dmdf_back_status_t;

endpackage

FILE: rtl/direct_mapped_duplicate_filter.sv
// Top level of the direct-mapped duplicate filter.
//
//  channel   handshake          payload
//  request   push / full        request (mode, target_address)
//  result    pop / empty        result (is_new, total_checks, shorted_checks)
//
// Check beats are taken one per cycle while no sweep or clear beat holds issue
// and the result queue has room; a beat passes the request queue, the table
// read, then compare and update into the result queue, and can then be popped.
// After reset and after every clear beat, the table is zeroed by a sweep over
// all 2**INDEX_BITS entries, one entry a cycle, during which no beat is issued.
// A stalled result queue holds back issue; the request queue still fills.
module direct_mapped_duplicate_filter #(
    parameter int unsigned INDEX_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  dmdf_pkg::dmdf_req_t request,
    output logic                empty,
    input  logic                pop,
    output dmdf_pkg::dmdf_res_t result
);

    logic                              req_empty;
    dmdf_pkg::dmdf_req_t               req_item;
    dmdf_pkg::dmdf_res_t               res_item;
    logic [dmdf_pkg::RES_DEPTH_LOG2:0] res_count;
    dmdf_pkg::dmdf_back_status_t       status;
    logic                              res_full;

    dmdf_fifo #(
        .T          (dmdf_pkg::dmdf_req_t),
        .DEPTH_LOG2 (dmdf_pkg::REQ_DEPTH_LOG2)
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (request),
        .full  (full),
        .pop   (status.take),
        .dout  (req_item),
        .empty (req_empty),
        .count ()
    );

    dmdf_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (!req_empty),
        .req_item  (req_item),
        .res_count (res_count),
        .res_item  (res_item),
        .status    (status)
    );

    dmdf_fifo #(
        .T          (dmdf_pkg::dmdf_res_t),
        .DEPTH_LOG2 (dmdf_pkg::RES_DEPTH_LOG2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (status.push),
        .din   (res_item),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty),
        .count (res_count)
    );

`ifndef SYNTHESIS
    a_no_issue_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        status.sweeping |-> !status.take)
        else $error("beat issued during table sweep");

    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.push |-> !res_full)
        else $error("result beat pushed into a full queue");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (status.take && req_item.mode == dmdf_pkg::MODE_CLEAR) |=>
        (status.push && !res_item.is_new && res_item.total_checks == '0
         && res_item.shorted_checks == '0))
        else $error("clear beat did not yield a zeroed result");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (status.take && req_item.mode == dmdf_pkg::MODE_CLEAR) |=> ##1 status.sweeping)
        else $error("clear beat did not start a sweep");
`endif

endmodule

FILE: rtl/dmdf_fifo.sv
// Small register queue used between the front, the back and the result ports.
module dmdf_fifo #(
    parameter type         T          = logic,
    parameter int unsigned DEPTH_LOG2 = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  T                    din,
    output logic                full,
    input  logic                pop,
    output T                    dout,
    output logic                empty,
    output logic [DEPTH_LOG2:0] count
);

    localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

    T                      slots_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg, rd_ptr_next;
    logic [DEPTH_LOG2:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = count_reg == (DEPTH_LOG2 + 1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign count   = count_reg;
    assign dout    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (DEPTH_LOG2 + 1)'(do_push) - (DEPTH_LOG2 + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/dmdf_back.sv
// Table memory, compare-and-update stage, counters and clearing sweep.
module dmdf_back #(
    parameter int unsigned INDEX_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  dmdf_pkg::dmdf_req_t               req_item,
    input  logic [dmdf_pkg::RES_DEPTH_LOG2:0] res_count,
    output dmdf_pkg::dmdf_res_t               res_item,
    output dmdf_pkg::dmdf_back_status_t       status
);

    localparam int unsigned CW = dmdf_pkg::RES_DEPTH_LOG2 + 1;

    logic [dmdf_pkg::ADDR_W-1:0]  table_mem [1 << INDEX_BITS];
    logic [dmdf_pkg::ADDR_W-1:0]  rdata_reg;

    logic                         sweep_reg, sweep_next;
    logic [INDEX_BITS-1:0]        sweep_idx_reg, sweep_idx_next;
    logic                         s1_valid_reg, s1_valid_next;
    dmdf_pkg::dmdf_req_t          s1_item_reg;
    logic                         fwd_valid_reg, fwd_valid_next;
    logic [INDEX_BITS-1:0]        fwd_slot_reg;
    logic [dmdf_pkg::ADDR_W-1:0]  fwd_data_reg;
    logic [dmdf_pkg::COUNT_W-1:0] check_reg, check_next;
    logic [dmdf_pkg::COUNT_W-1:0] short_reg, short_next;

    logic                         take;
    logic [CW-1:0]                occupied;
    logic [INDEX_BITS-1:0]        s1_slot;
    logic [dmdf_pkg::ADDR_W-1:0]  entry;
    logic                         is_check, is_clear, hit, do_store;
    logic                         wr_en;
    logic [INDEX_BITS-1:0]        wr_addr;
    logic [dmdf_pkg::ADDR_W-1:0]  wr_data;

    // Issue only when the result queue is sure to have room for the beat in flight.
    assign occupied = res_count + CW'(s1_valid_reg);
    assign take     = req_valid && !sweep_reg && occupied < CW'(dmdf_pkg::RES_DEPTH)
                      && !(s1_valid_reg && s1_item_reg.mode == dmdf_pkg::MODE_CLEAR);

    assign s1_slot  = s1_item_reg.target_address[INDEX_BITS-1:0];
    assign is_check = s1_valid_reg && s1_item_reg.mode == dmdf_pkg::MODE_CHECK;
    assign is_clear = s1_valid_reg && s1_item_reg.mode == dmdf_pkg::MODE_CLEAR;

    // The write made by the previous beat is not yet in the read data.
    assign entry    = (fwd_valid_reg && fwd_slot_reg == s1_slot) ? fwd_data_reg : rdata_reg;
    assign hit      = entry == s1_item_reg.target_address;
    assign do_store = is_check && !hit && entry == '0;

    always_comb
    begin
        check_next     = check_reg;
        short_next     = short_reg;
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        if (is_clear)
        begin
            check_next     = '0;
            short_next     = '0;
            sweep_next     = 1'b1;
            sweep_idx_next = '0;
        end
        else if (is_check)
        begin
            if (check_reg != dmdf_pkg::COUNT_MAX)
            begin
                check_next = check_reg + 1'b1;
            end
            if (hit && short_reg != dmdf_pkg::COUNT_MAX)
            begin
                short_next = short_reg + 1'b1;
            end
        end
        if (sweep_reg)
        begin
            sweep_idx_next = sweep_idx_reg + 1'b1;
            if (sweep_idx_reg == '1)
            begin
                sweep_next = 1'b0;
            end
        end
        s1_valid_next  = take;
        fwd_valid_next = do_store;
    end

    assign wr_en   = sweep_reg || do_store;
    assign wr_addr = sweep_reg ? sweep_idx_reg : s1_slot;
    assign wr_data = sweep_reg ? '0 : s1_item_reg.target_address;

    always_comb
    begin
        res_item.is_new         = is_check && !hit;
        res_item.total_checks   = check_next;
        res_item.shorted_checks = short_next;
    end

    assign status.take     = take;
    assign status.sweeping = sweep_reg;
    assign status.push     = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            check_reg     <= '0;
            short_reg     <= '0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            check_reg     <= check_next;
            short_reg     <= short_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= req_item;
        end
        fwd_slot_reg <= s1_slot;
        fwd_data_reg <= s1_item_reg.target_address;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= table_mem[req_item.target_address[INDEX_BITS-1:0]];
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

endmodule
